// ----- hw/rtl/dop_pkg.sv -----
// ----------------------------------------------------------------------------
// DoP packer package
// Register indexes, marker bytes and the byte/sample formatting helpers.
// ----------------------------------------------------------------------------
package dop_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int CH_CNT_W   = 4;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_CHANNEL_COUNT = 3'd0;
	localparam cfg_idx_t REG_MSB_FIRST     = 3'd1;
	localparam cfg_idx_t REG_PLANAR_LAYOUT = 3'd2;
	localparam cfg_idx_t REG_WIDE_OUTPUT   = 3'd3;

	localparam logic [CH_CNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

	localparam logic [7:0] MARKER_EVEN = 8'h05;
	localparam logic [7:0] MARKER_ODD  = 8'hFA;

	// swap nibbles, then bit pairs, then single bits
	function automatic logic [7:0] flip_byte(input logic [7:0] v);
		logic [7:0] t;
		t = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
		t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
		t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
		return t;
	endfunction

	function automatic logic [31:0] pack_sample(
		input logic [7:0] first,
		input logic [7:0] second,
		input logic       odd_phase,
		input logic       wide
	);
		logic [23:0] w;
		w = {(odd_phase ? MARKER_ODD : MARKER_EVEN), second, first};
		return wide ? {w, 8'h00} : {8'h00, w};
	endfunction

endpackage

// ----- hw/rtl/dop_store.sv -----
// ----------------------------------------------------------------------------
// DoP byte store
// One write port and two read ports, with registered read data.
// ----------------------------------------------------------------------------
module dop_store #(
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [7:0]    rdata_a,
	output logic [7:0]    rdata_b
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- hw/rtl/dop_div.sv -----
// ----------------------------------------------------------------------------
// DoP region divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dop_div #(
	parameter int DW = 8,
	parameter int VW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   quo_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   div_q;
	logic [VW:0]     rem_sh;
	logic            ge;
	logic [VW:0]     diff;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign diff   = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/dsd_over_pcm_packer.sv -----
// ----------------------------------------------------------------------------
// DSD over PCM packer
// Gathers DSD bytes in a block store and emits DoP carrier samples.
// ----------------------------------------------------------------------------
// Sequence: interleaved, the byte that completes a frame moves the sequencer
//   through ST_PREP to ST_EMIT, where each sample is registered; planar, the
//   block-end byte first starts the region divider (ST_DIV) before ST_PREP.
// Throughput: one byte per cycle while gathering; while emitting, one sample
//   per cycle unless smp_ready stalls it, and bytes are held off meanwhile.
// Reset: counters, marker phase and registers return to defaults; the store
//   itself is not cleared and needs no clearing pass.
module dsd_over_pcm_packer #(
	parameter int BLOCK_BYTES  = 128,
	parameter int MAX_CHANNELS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dop_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dop_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           dsd_valid,
	output logic                           dsd_ready,
	input  logic [7:0]                     dsd_byte,
	input  logic                           block_end,
	output logic                           smp_valid,
	input  logic                           smp_ready,
	output logic [31:0]                    sample_word,
	output logic [2:0]                     channel_index,
	output logic                           run_last
);

	localparam int AW  = $clog2(BLOCK_BYTES);
	localparam int CW  = $clog2(BLOCK_BYTES + 1);
	localparam int CHW = dop_pkg::CH_CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_PREP = 4'b0100,
		ST_EMIT = 4'b1000
	} seq_state_t;

	// configuration
	logic [CHW-1:0] chan_cnt_q;
	logic           msb_first_q;
	logic           planar_q;
	logic           wide_q;

	// gathering
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  cnt_n;
	logic           has_room;
	logic [CHW-1:0] chs;
	logic [CHW:0]   frame_bytes;
	logic           accept;
	logic           fire_il;
	logic           fire_pl;
	logic           cfg_clr;

	// sequencer
	seq_state_t     state_q;
	logic [AW-1:0]  a_q;
	logic [AW-1:0]  base_q;
	logic [2:0]     ch_q;
	logic [2:0]     last_ch_q;
	logic [CW-1:0]  frame_q;
	logic [CW-1:0]  last_frame_q;
	logic [CW-1:0]  chan_inc_q;
	logic [CW-1:0]  pair_off_q;
	logic           phase_q;
	logic           load;
	logic           last_ch_hit;
	logic           last_fr_hit;
	logic [AW-1:0]  base_next;
	logic [CW:0]    a_step;
	logic [AW-1:0]  next_a;
	logic [AW-1:0]  rd_a;
	logic [CW:0]    rd_b_sum;
	logic [AW-1:0]  rd_b;
	logic [7:0]     rdata_a;
	logic [7:0]     rdata_b;
	logic [7:0]     first_b;
	logic [7:0]     second_b;

	// divider
	logic           div_done;
	logic [CW-1:0]  region;
	logic [CW-1:0]  frames;

	// output register
	logic           smp_valid_q;
	logic [31:0]    sample_q;
	logic [2:0]     chidx_q;
	logic           run_last_q;

	// ---------------- configuration port ----------------
	assign cfg_clr = cfg_we && (cfg_index inside {dop_pkg::REG_CHANNEL_COUNT,
		dop_pkg::REG_PLANAR_LAYOUT});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q  <= dop_pkg::CHANNEL_COUNT_RESET;
			msb_first_q <= 1'b0;
			planar_q    <= 1'b0;
			wide_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dop_pkg::REG_CHANNEL_COUNT: chan_cnt_q  <= cfg_data[CHW-1:0];
				dop_pkg::REG_MSB_FIRST:     msb_first_q <= cfg_data[0];
				dop_pkg::REG_PLANAR_LAYOUT: planar_q    <= cfg_data[0];
				dop_pkg::REG_WIDE_OUTPUT:   wide_q      <= cfg_data[0];
				default: ; // unknown register: drop the write
			endcase
		end
	end

	// ---------------- byte gathering ----------------
	// Clamp the channel count; a count of zero never completes a frame.
	assign chs = (chan_cnt_q > CHW'(MAX_CHANNELS)) ? CHW'(MAX_CHANNELS) : chan_cnt_q;
	assign frame_bytes = {chs, 1'b0};

	assign dsd_ready = (state_q == ST_IDLE);
	assign accept    = dsd_valid && dsd_ready;

	// A full store ignores the byte, but block_end still counts.
	assign has_room = cnt_q < CW'(BLOCK_BYTES);
	assign cnt_n    = has_room ? cnt_q + CW'(1) : cnt_q;

	assign fire_il = accept && !planar_q && (chs != '0) && (cnt_n >= CW'(frame_bytes));
	assign fire_pl = accept && planar_q && block_end && (chs != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			// a channel count or layout write discards the partial block
			if (cfg_clr) begin
				cnt_q <= '0;
			end else if (accept) begin
				cnt_q <= (block_end || fire_il) ? '0 : cnt_n;
			end
		end
	end

	dop_store #(
		.DEPTH (BLOCK_BYTES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.we      (accept && has_room),
		.waddr   (cnt_q[AW-1:0]),
		.wdata   (dsd_byte),
		.raddr_a (rd_a),
		.raddr_b (rd_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Planar region length = count / channels; frames = region / 2.
	dop_div #(
		.DW (CW),
		.VW (CHW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (fire_pl),
		.dividend (cnt_n),
		.divisor  (chs),
		.done     (div_done),
		.quotient (region)
	);

	assign frames = region >> 1;

	// ---------------- emission sequencer ----------------
	// Sample of channel c in frame f reads entries a and a + pair_off:
	//   interleaved a = c, pair_off = channels
	//   planar      a = c * region + 2f, pair_off = 1
	// The read address runs one step ahead so that the registered read data
	// always belongs to the sample held in a_q.
	assign load        = (state_q == ST_EMIT) && (!smp_valid_q || smp_ready);
	assign last_ch_hit = (ch_q == last_ch_q);
	assign last_fr_hit = (frame_q == last_frame_q);
	assign base_next   = base_q + AW'(2);
	assign a_step      = (CW+1)'(a_q) + (CW+1)'(chan_inc_q);
	assign next_a      = last_ch_hit ? base_next : a_step[AW-1:0];
	assign rd_a        = load ? next_a : a_q;
	assign rd_b_sum    = (CW+1)'(rd_a) + (CW+1)'(pair_off_q);
	assign rd_b        = rd_b_sum[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			a_q          <= '0;
			base_q       <= '0;
			ch_q         <= '0;
			last_ch_q    <= '0;
			frame_q      <= '0;
			last_frame_q <= '0;
			chan_inc_q   <= '0;
			pair_off_q   <= '0;
			phase_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (fire_il || fire_pl) begin
						a_q          <= '0;
						base_q       <= '0;
						ch_q         <= '0;
						frame_q      <= '0;
						last_frame_q <= '0;
						last_ch_q    <= 3'(chs - CHW'(1));
					end
					if (fire_il) begin
						chan_inc_q <= CW'(1);
						pair_off_q <= CW'(chs);
						state_q    <= ST_PREP;
					end else if (fire_pl) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						chan_inc_q   <= region;
						pair_off_q   <= CW'(1);
						last_frame_q <= frames - CW'(1);
						// too few bytes for one whole frame: drop the block
						state_q      <= (frames == '0) ? ST_IDLE : ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						a_q <= next_a;
						if (last_ch_hit) begin
							ch_q    <= '0;
							phase_q <= ~phase_q;
							base_q  <= base_next;
							frame_q <= frame_q + CW'(1);
							if (last_fr_hit) begin
								state_q <= ST_IDLE;
							end
						end else begin
							ch_q <= ch_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- output register ----------------
	assign first_b  = msb_first_q ? dop_pkg::flip_byte(rdata_a) : rdata_a;
	assign second_b = msb_first_q ? dop_pkg::flip_byte(rdata_b) : rdata_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_q <= 1'b0;
		end else if (load) begin
			smp_valid_q <= 1'b1;
		end else if (smp_ready) begin
			smp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_q   <= dop_pkg::pack_sample(first_b, second_b, phase_q, wide_q);
			chidx_q    <= ch_q;
			run_last_q <= last_ch_hit && last_fr_hit;
		end
	end

	assign smp_valid     = smp_valid_q;
	assign sample_word   = sample_q;
	assign channel_index = chidx_q;
	assign run_last      = run_last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(BLOCK_BYTES))
		else $error("store count beyond capacity");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (ch_q <= last_ch_q && frame_q <= last_frame_q))
		else $error("emission counters out of range");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_no_byte_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_il || fire_pl) |=> !dsd_ready)
		else $error("byte taken while a block is being emitted");
`endif

endmodule

// ----- verif/tb_dsd_over_pcm_packer.sv -----
// ----------------------------------------------------------------------------
// DSD over PCM packer testbench
// Feeds DSD bytes through the valid/ready input, rewrites the layout registers
// between phases and checks every DoP carrier sample, field by field, against
// a cycle-free model of the packer kept inside the bench.
// ----------------------------------------------------------------------------
module tb_dsd_over_pcm_packer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCK_BYTES    = 128;
	localparam int MAX_CH         = 8;
	localparam int RESET_CYCLES   = 7;
	localparam int IDLE_PCT       = 11;
	localparam int SETTLE_CYCLES  = 16;    // covers the planar divider latency
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TARGET_ITEMS   = 310;
	localparam int PRINT_CAP      = 40;

	// index outside the register map, must be ignored by the block
	localparam dop_pkg::cfg_idx_t REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  ch;
		logic        last;
	} dop_sample_t;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	// val is the DSD byte or the register index, arg the block end flag or the
	// register data; word is the first sample of the transfer when chk is set
	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  val;
		logic [3:0]  arg;
		logic        chk;
		logic [31:0] word;
	} dir_row_t;

	localparam int DIR_ROWS = 34;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// reset settings: two channels, interleaved, packed 24-bit
		'{ROW_BYTE, 8'h00, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'hFF, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'hFF, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h00, 4'h0, 1'b1, 32'h0005_FF00},
		// second frame, block end on the byte that completes it
		'{ROW_BYTE, 8'h80, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h01, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h7F, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'hFE, 4'h1, 1'b1, 32'h00FA_7F80},
		// half a frame, dropped at block end
		'{ROW_BYTE, 8'hAA, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h55, 4'h1, 1'b0, 32'h0},
		// bit reversal and 24-in-32 output, plus a write to no register
		'{ROW_CFG,  8'(dop_pkg::REG_MSB_FIRST),   4'h1, 1'b0, 32'h0},
		'{ROW_CFG,  8'(dop_pkg::REG_WIDE_OUTPUT), 4'h3, 1'b0, 32'h0},
		'{ROW_CFG,  8'(REG_UNUSED),               4'hF, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h01, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h80, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'hF0, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h0F, 4'h0, 1'b1, 32'h050F_8000},
		// one byte gathered, then thrown away by a channel count write
		'{ROW_BYTE, 8'h3C, 4'h0, 1'b0, 32'h0},
		'{ROW_CFG,  8'(dop_pkg::REG_CHANNEL_COUNT), 4'h1, 1'b0, 32'h0},
		'{ROW_CFG,  8'(dop_pkg::REG_MSB_FIRST),     4'h0, 1'b0, 32'h0},
		'{ROW_CFG,  8'(dop_pkg::REG_WIDE_OUTPUT),   4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h12, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h34, 4'h0, 1'b1, 32'h00FA_3412},
		// zero channels never completes a frame
		'{ROW_CFG,  8'(dop_pkg::REG_CHANNEL_COUNT), 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h77, 4'h1, 1'b0, 32'h0},
		// planar stereo block; reversal switched on mid-block applies at emit
		'{ROW_CFG,  8'(dop_pkg::REG_CHANNEL_COUNT), 4'h2, 1'b0, 32'h0},
		'{ROW_CFG,  8'(dop_pkg::REG_PLANAR_LAYOUT), 4'h1, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h11, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h22, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h33, 4'h0, 1'b0, 32'h0},
		'{ROW_CFG,  8'(dop_pkg::REG_MSB_FIRST),     4'h1, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h44, 4'h0, 1'b0, 32'h0},
		'{ROW_BYTE, 8'h55, 4'h1, 1'b1, 32'h0005_4488},
		'{ROW_BYTE, 8'h99, 4'h1, 1'b0, 32'h0}
	};

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	dop_pkg::cfg_idx_t              cfg_index;
	logic [dop_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           dsd_valid;
	logic                           dsd_ready;
	logic [7:0]                     dsd_byte;
	logic                           block_end;
	logic                           smp_valid;
	logic                           smp_ready;
	logic [31:0]                    sample_word;
	logic [2:0]                     channel_index;
	logic                           run_last;

	// bench copy of the packer state and registers
	logic [7:0]     blk_store [BLOCK_BYTES];
	int unsigned    blk_count;
	bit             mark_odd;
	logic [3:0]     m_chan;
	bit             m_rev;
	bit             m_planar;
	bit             m_wide;

	dop_sample_t    sample_q [$];

	int unsigned    errors;
	int unsigned    bytes_sent;
	int unsigned    samples_seen;
	int unsigned    overflow_bytes;
	int unsigned    frames_emitted;
	int unsigned    planar_blocks;
	int unsigned    settings_used;
	int unsigned    quiet_cycles;
	bit             gapless;
	bit             hold_req;

	dsd_over_pcm_packer #(
		.BLOCK_BYTES  (BLOCK_BYTES),
		.MAX_CHANNELS (MAX_CH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.dsd_valid     (dsd_valid),
		.dsd_ready     (dsd_ready),
		.dsd_byte      (dsd_byte),
		.block_end     (block_end),
		.smp_valid     (smp_valid),
		.smp_ready     (smp_ready),
		.sample_word   (sample_word),
		.channel_index (channel_index),
		.run_last      (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_error(input string what);
		if (errors < PRINT_CAP)
			$display("ERROR %0t: %s", $time, what);
		errors++;
	endtask

	// ---------------------------------------------------------------- model

	function automatic logic [7:0] mirror_bits(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++)
			r[i] = v[7 - i];
		return r;
	endfunction

	// counts above the supported maximum behave as the maximum
	function automatic int unsigned active_chs();
		return (m_chan > MAX_CH) ? MAX_CH : m_chan;
	endfunction

	// hand out the marker of the next frame and advance the phase
	function automatic logic [7:0] next_marker();
		logic [7:0] m;
		m = mark_odd ? dop_pkg::MARKER_ODD : dop_pkg::MARKER_EVEN;
		mark_odd = ~mark_odd;
		frames_emitted++;
		return m;
	endfunction

	function automatic void queue_sample(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] mark, input int unsigned ch);
		dop_sample_t s;
		logic [23:0] body;
		body = {mark, m_rev ? mirror_bits(second) : second,
			m_rev ? mirror_bits(first) : first};
		s.word = m_wide ? {body, 8'h00} : {8'h00, body};
		s.ch   = ch[2:0];
		s.last = 1'b0;
		sample_q.push_back(s);
	endfunction

	function automatic void model_reset();
		blk_count = 0;
		mark_odd  = 1'b0;
		m_chan    = dop_pkg::CHANNEL_COUNT_RESET;
		m_rev     = 1'b0;
		m_planar  = 1'b0;
		m_wide    = 1'b0;
	endfunction

	function automatic void model_write(input dop_pkg::cfg_idx_t idx,
			input logic [3:0] data);
		case (idx)
			dop_pkg::REG_CHANNEL_COUNT: begin
				m_chan    = data;
				blk_count = 0;
			end
			dop_pkg::REG_MSB_FIRST: m_rev = data[0];
			dop_pkg::REG_PLANAR_LAYOUT: begin
				m_planar  = data[0];
				blk_count = 0;
			end
			dop_pkg::REG_WIDE_OUTPUT: m_wide = data[0];
			default: ;
		endcase
	endfunction

	// store one byte, queue the samples it releases, return how many
	function automatic int unsigned predict_byte(input logic [7:0] b, input bit last);
		int unsigned chs, n, frames, region, base;
		logic [7:0]  mark;
		dop_sample_t tail;
		chs = active_chs();
		n   = 0;
		if (blk_count < BLOCK_BYTES) begin
			blk_store[blk_count] = b;
			blk_count++;
		end else begin
			overflow_bytes++;
		end
		if (!m_planar) begin
			if (chs != 0 && blk_count >= 2 * chs) begin
				mark = next_marker();
				for (int c = 0; c < chs; c++) begin
					queue_sample(blk_store[c], blk_store[chs + c], mark, c);
					n++;
				end
				blk_count = 0;
			end
			if (last)
				blk_count = 0;
		end else if (last) begin
			if (chs != 0) begin
				frames = blk_count / (2 * chs);
				region = blk_count / chs;
				if (frames != 0)
					planar_blocks++;
				for (int f = 0; f < frames; f++) begin
					mark = next_marker();
					for (int c = 0; c < chs; c++) begin
						base = c * region + 2 * f;
						queue_sample(blk_store[base], blk_store[base + 1], mark, c);
						n++;
					end
				end
			end
			blk_count = 0;
		end
		if (n != 0) begin
			tail = sample_q.pop_back();
			tail.last = 1'b1;
			sample_q.push_back(tail);
		end
		return n;
	endfunction

	// ---------------------------------------------------------------- drivers

	// offer one byte, hold it until the transfer, then predict its samples
	task automatic push_byte(input logic [7:0] b, input bit last, output int unsigned n);
		if (!gapless && $urandom_range(99) < IDLE_PCT) begin
			dsd_valid <= 1'b0;
			@(posedge clk);
		end
		dsd_valid <= 1'b1;
		dsd_byte  <= b;
		block_end <= last;
		do
			@(posedge clk);
		while (dsd_ready !== 1'b1);
		n = predict_byte(b, last);
		bytes_sent++;
	endtask

	// drop valid, wait for every expected sample, then let the block go quiet
	task automatic settle();
		dsd_valid <= 1'b0;
		while (sample_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(input dop_pkg::cfg_idx_t idx,
			input logic [dop_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		model_write(idx, data);
	endtask

	task automatic apply_config(input logic [3:0] chan, input bit rev, input bit planar,
			input bit wide);
		settle();
		// single-bit registers get random upper data bits, which must not matter
		write_reg(dop_pkg::REG_CHANNEL_COUNT, chan);
		write_reg(dop_pkg::REG_MSB_FIRST, {3'($urandom_range(7)), rev});
		write_reg(dop_pkg::REG_PLANAR_LAYOUT, {3'($urandom_range(7)), planar});
		write_reg(dop_pkg::REG_WIDE_OUTPUT, {3'($urandom_range(7)), wide});
		if ($urandom_range(3) == 0)
			write_reg(REG_UNUSED, 4'($urandom));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// a run of random bytes; block end on the last byte unless scattered,
	// optionally toggling the bit order halfway through
	task automatic send_run(input int unsigned len, input bit scatter, input bit flip_mid);
		bit          last;
		int unsigned n;
		for (int i = 0; i < len; i++) begin
			if (flip_mid && i == len / 2) begin
				settle();
				write_reg(dop_pkg::REG_MSB_FIRST, {3'b000, ~m_rev});
				cfg_we <= 1'b0;
			end
			last = scatter ? ($urandom_range(7) == 0) : (i == len - 1);
			push_byte(8'($urandom), last, n);
		end
	endtask

	// mostly whole-frame blocks, some ragged ones, a few with stray ends
	task automatic random_block();
		int unsigned chs, len, pick;
		bit          scatter;
		chs     = active_chs();
		pick    = $urandom_range(99);
		scatter = 1'b0;
		if (chs == 0)
			len = $urandom_range(1, 12);
		else if (pick < 70)
			len = 2 * chs * (m_planar ? $urandom_range(1, 3) : $urandom_range(1, 4));
		else if (pick < 88)
			len = $urandom_range(1, 2 * chs + 5);
		else begin
			len     = $urandom_range(2, 20);
			scatter = 1'b1;
		end
		send_run(len, scatter, m_planar && pick < 20);
	endtask

	// ---------------------------------------------------------------- receiver

	// random back-pressure; on request hold off for a long stretch
	initial begin : sample_sink
		smp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				smp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				smp_ready <= 1'b1;
			end else begin
				smp_ready <= gapless || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// compare each sample transfer with the oldest expectation
	always @(posedge clk) begin : check_samples
		dop_sample_t want;
		if (smp_valid === 1'b1 && smp_ready === 1'b1) begin
			samples_seen++;
			if (sample_q.size() == 0) begin
				report_error($sformatf("sample %h ch %0d with nothing expected",
					sample_word, channel_index));
			end else begin
				want = sample_q.pop_front();
				if (sample_word !== want.word)
					report_error($sformatf("sample_word %h, expected %h",
						sample_word, want.word));
				if (channel_index !== want.ch)
					report_error($sformatf("channel_index %0d, expected %0d",
						channel_index, want.ch));
				if (run_last !== want.last)
					report_error($sformatf("run_last %b, expected %b on sample %h",
						run_last, want.last, want.word));
			end
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((dsd_valid && dsd_ready) || (smp_valid && smp_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d samples outstanding",
				quiet_cycles, sample_q.size());
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		dir_row_t    row;
		dop_sample_t fix;
		int unsigned n;
		bit          cfg_open;
		logic [3:0]  chan;

		errors         = 0;
		bytes_sent     = 0;
		samples_seen   = 0;
		overflow_bytes = 0;
		frames_emitted = 0;
		planar_blocks  = 0;
		settings_used  = 0;
		quiet_cycles   = 0;
		gapless        = 1'b0;
		hold_req       = 1'b0;
		cfg_open       = 1'b0;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= dop_pkg::REG_CHANNEL_COUNT;
		cfg_data  <= '0;
		dsd_valid <= 1'b0;
		dsd_byte  <= 8'h00;
		block_end <= 1'b0;
		model_reset();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table; register rows wait for an idle block first
		for (int r = 0; r < DIR_ROWS; r++) begin
			row = dir_rows[r];
			if (row.kind == ROW_CFG) begin
				if (!cfg_open)
					settle();
				cfg_open = 1'b1;
				write_reg(dop_pkg::cfg_idx_t'(row.val), row.arg);
			end else begin
				if (cfg_open)
					cfg_we <= 1'b0;
				cfg_open = 1'b0;
				push_byte(row.val, row.arg[0], n);
				// pin the first sample of this transfer to the hand-worked value
				if (row.chk && n != 0) begin
					fix = sample_q[sample_q.size() - n];
					fix.word = row.word;
					sample_q[sample_q.size() - n] = fix;
				end
			end
		end

		// overfull planar block, channel count beyond the maximum, all options on;
		// the block end lands on a byte the full store ignores
		apply_config(4'hF, 1'b1, 1'b1, 1'b1);
		send_run(BLOCK_BYTES + 2, 1'b0, 1'b0);

		// eight interleaved channels with no idling on either side
		gapless = 1'b1;
		apply_config(4'(MAX_CH), 1'b0, 1'b0, 1'b0);
		send_run(4 * MAX_CH, 1'b0, 1'b0);
		gapless = 1'b0;

		// stall the receiver while mono frames keep coming, so the input backs up
		apply_config(4'd1, 1'($urandom), 1'b0, 1'b1);
		hold_req = 1'b1;
		send_run(32, 1'b0, 1'b0);

		// random settings; mostly valid counts, now and then zero or too many
		while (bytes_sent < TARGET_ITEMS) begin
			chan = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) :
				4'($urandom_range(1, MAX_CH));
			gapless = (settings_used % 7 == 6);
			apply_config(chan, 1'($urandom), 1'($urandom), 1'($urandom));
			repeat ($urandom_range(1, 4)) random_block();
		end
		gapless = 1'b0;

		settle();
		$display("Sent %0d DSD bytes (%0d into a full store) over %0d register settings.",
			bytes_sent, overflow_bytes, settings_used);
		$display("Checked %0d carrier samples from %0d frames, %0d planar blocks.",
			samples_seen, frames_emitted, planar_blocks);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
